// ----- hdl/rdqd_pkg.sv -----
// ----------------------------------------------------------------------------
// rdqd_pkg
// shared types for the ring deque: word formats, operation codes and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package rdqd_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP_NEW  = 3'd1,
    OP_POP_OLD  = 3'd2,
    OP_DELETE   = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] count;
    logic               full_res;
    logic               empty_res;
  } out_word_t;

  typedef enum logic [1:0] {
    RES_FAIL = 2'd0,
    RES_OK   = 2'd1,
    RES_READ = 2'd2,
    RES_DEL  = 2'd3
  } res_src_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_DEL  = 3'b100
  } state_t;

  typedef struct packed {
    logic     push;
    logic     pop_new;
    logic     pop_old;
    logic     clear;
    logic     del_start;
    logic     del_run;
    logic     load_out;
    res_src_t res_src;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic del_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/rdqd_ram.sv -----
// ----------------------------------------------------------------------------
// rdqd_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module rdqd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/rdqd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdqd_ctrl
// sequencer: decodes the operation of an accepted word and steps the
// datapath through pop reads and the delete walk
// ----------------------------------------------------------------------------
module rdqd_ctrl
  import rdqd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] operation,
  input  dp_sts_t         sts,
  output ctl_cmd_t        cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_comb begin
    cmd       = '0;
    cmd.res_src = RES_FAIL;
    state_nxt = state_r;
    in_stall  = 1'b1;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        accept   = in_valid && sts.out_free;
        if (accept) begin
          unique case (op_t'(operation))
            OP_PUSH: begin
              cmd.push     = !sts.full;
              cmd.load_out = 1'b1;
              cmd.res_src  = sts.full ? RES_FAIL : RES_OK;
            end
            OP_POP_NEW: begin
              if (sts.empty) begin
                cmd.load_out = 1'b1;
              end else begin
                cmd.pop_new = 1'b1;
                state_nxt   = ST_POP;
              end
            end
            OP_POP_OLD: begin
              if (sts.empty) begin
                cmd.load_out = 1'b1;
              end else begin
                cmd.pop_old = 1'b1;
                state_nxt   = ST_POP;
              end
            end
            OP_DELETE: begin
              cmd.del_start = 1'b1;
              state_nxt     = ST_DEL;
            end
            OP_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.load_out = 1'b1;
              cmd.res_src  = sts.empty ? RES_FAIL : RES_OK;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd.load_out = 1'b1;
        cmd.res_src  = RES_READ;
        state_nxt    = ST_IDLE;
      end
      ST_DEL: begin
        cmd.del_run = 1'b1;
        if (!sts.del_busy) begin
          cmd.load_out = 1'b1;
          cmd.res_src  = RES_DEL;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/rdqd_dpath.sv -----
// ----------------------------------------------------------------------------
// rdqd_dpath
// slot pointers, occupancy, entry ram, delete walk pipeline and the
// output word register
// ----------------------------------------------------------------------------
module rdqd_dpath
  import rdqd_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] data_in,
  input  ctl_cmd_t          cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [PTR_W-1:0]      newest_r, newest_nxt;
  logic [PTR_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      rd_left_r, rd_left_nxt;
  logic                  rvalid_r, removed_r, removed_nxt;
  logic [ENTRY_BITS-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic [ENTRY_BITS-1:0] din_e;
  logic [ENTRY_BITS-1:0] rd_data;
  logic [DATA_W-1:0]     rd_word;
  logic [COUNT_W-1:0]    count_field;
  logic                  del_issue, keep, drop;
  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic [PTR_W-1:0]      newest_inc, newest_dec, oldest_inc;

  generate
    if (ENTRY_BITS > DATA_W) begin : g_wide
      assign din_e   = {{(ENTRY_BITS-DATA_W){1'b0}}, data_in};
      assign rd_word = rd_data[DATA_W-1:0];
    end else if (ENTRY_BITS == DATA_W) begin : g_same
      assign din_e   = data_in;
      assign rd_word = rd_data;
    end else begin : g_narrow
      assign din_e   = data_in[ENTRY_BITS-1:0];
      assign rd_word = {{(DATA_W-ENTRY_BITS){1'b0}}, rd_data};
    end
    if (CNT_W >= COUNT_W) begin : g_cnt_wide
      assign count_field = count_nxt[COUNT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_field = {{(COUNT_W-CNT_W){1'b0}}, count_nxt};
    end
  endgenerate

  assign newest_inc = (newest_r == LAST_SLOT) ? '0 : newest_r + PTR_W'(1);
  assign newest_dec = (newest_r == '0) ? LAST_SLOT : newest_r - PTR_W'(1);
  assign oldest_inc = (oldest_r == LAST_SLOT) ? '0 : oldest_r + PTR_W'(1);

  assign del_issue = cmd.del_run && (rd_left_r != '0);
  assign keep      = cmd.del_run && rvalid_r && (rd_data != key_r);
  assign drop      = cmd.del_run && rvalid_r && (rd_data == key_r);

  assign wr_en   = cmd.push || keep;
  assign wr_addr = newest_r;
  assign wr_data = cmd.push ? din_e : rd_data;
  assign rd_en   = cmd.pop_new || cmd.pop_old || del_issue;
  assign rd_addr = cmd.pop_new ? newest_dec : oldest_r;

  rdqd_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    newest_nxt  = newest_r;
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    rd_left_nxt = rd_left_r;
    removed_nxt = removed_r;
    key_nxt     = key_r;
    if (cmd.push || keep) begin
      newest_nxt = newest_inc;
    end else if (cmd.pop_new) begin
      newest_nxt = newest_dec;
    end
    if (cmd.pop_old || del_issue) begin
      oldest_nxt = oldest_inc;
    end else if (cmd.clear) begin
      oldest_nxt = newest_r;
    end
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_new || cmd.pop_old || drop) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.del_start) begin
      rd_left_nxt = count_r;
      removed_nxt = 1'b0;
      key_nxt     = din_e;
    end else begin
      if (del_issue) begin
        rd_left_nxt = rd_left_r - CNT_W'(1);
      end
      if (drop) begin
        removed_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (cmd.load_out) begin
      out_valid_nxt          = 1'b1;
      out_word_nxt.data_out  = '0;
      out_word_nxt.count     = count_field;
      out_word_nxt.full_res  = (count_nxt == FULL_CNT);
      out_word_nxt.empty_res = (count_nxt == '0);
      case (cmd.res_src)
        RES_OK: begin
          out_word_nxt.ok = 1'b1;
        end
        RES_READ: begin
          out_word_nxt.ok       = 1'b1;
          out_word_nxt.data_out = rd_word;
        end
        RES_DEL: begin
          out_word_nxt.ok = removed_r;
        end
        default: begin
          out_word_nxt.ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      rd_left_r   <= '0;
      rvalid_r    <= 1'b0;
      removed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      rd_left_r   <= rd_left_nxt;
      rvalid_r    <= del_issue;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == FULL_CNT);
  assign sts.del_busy = (rd_left_r != '0) || rvalid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hdl/ring_deque_with_delete.sv -----
// ----------------------------------------------------------------------------
// ring_deque_with_delete
// circular store usable as stack or queue, with delete of all matching
// entries and clear
//
// in_word carries an operation code and a data word; every accepted word
// returns exactly one out_word with ok flag, read data, count and full and
// empty flags. push, clear and unused codes answer in the cycle after accept;
// pops answer through the registered ram read port and then the output
// register. delete walks the held entries through the ram read port, one
// entry per cycle with the compare in the cycle after each read, and answers
// through the output register once the walk is done. a new word is taken
// as soon as the previous one has finished and the output register is free
// or being emptied in the same cycle. reset empties the store with both
// slot pointers at zero; entries are not cleared. a stalled out_word holds,
// and in_stall rises until the output register drains.
// ----------------------------------------------------------------------------
module ring_deque_with_delete
  import rdqd_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rdqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (in_word.operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdqd_dpath #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_in   (in_word.data_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for ring_deque_with_delete: a shadow deque predicts the
// status word of every accepted command word, results are compared field by
// field in order, both handshakes idle and stall in random bursts
// ----------------------------------------------------------------------------
module testbench;
  import rdqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned ENTRY_BITS     = 32;
  localparam int unsigned RANDOM_WORDS   = 1600;
  localparam int unsigned QUIET_TAIL     = 200;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned OP_SPARE_FIRST = 5;
  localparam int unsigned OP_SPARE_LAST  = 7;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  class deque_tracker;
    logic [DATA_W-1:0] held[$];
    out_word_t         pending_status[$];
    int unsigned       mismatches;

    function out_word_t predict_status(in_word_t w);
      out_word_t         r;
      logic [DATA_W-1:0] kept[$];
      int unsigned       held_before;
      r = '0;
      case (w.operation)
        OP_PUSH: begin
          if (held.size() < DEPTH) begin
            held.push_back(w.data_in);
            r.ok = 1'b1;
          end
        end
        OP_POP_NEW: begin
          if (held.size() != 0) begin
            r.data_out = held.pop_back();
            r.ok = 1'b1;
          end
        end
        OP_POP_OLD: begin
          if (held.size() != 0) begin
            r.data_out = held.pop_front();
            r.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          held_before = held.size();
          foreach (held[i]) begin
            if (held[i] != w.data_in) kept.push_back(held[i]);
          end
          held = kept;
          r.ok = (held_before != 0) && (held.size() < held_before);
        end
        OP_CLEAR: begin
          r.ok = (held.size() != 0);
          held.delete();
        end
        default: ;
      endcase
      r.count     = COUNT_W'(held.size());
      r.full_res  = (held.size() == DEPTH);
      r.empty_res = (held.size() == 0);
      return r;
    endfunction

    function void note_word(in_word_t w);
      pending_status.push_back(predict_status(w));
    endfunction

    function void compare(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: status word with nothing expected, expected none, actual %p",
                 $time, got);
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare("ok", DATA_W'(want.ok), DATA_W'(got.ok));
      compare("data_out", want.data_out, got.data_out);
      compare("count", DATA_W'(want.count), DATA_W'(got.count));
      compare("full_res", DATA_W'(want.full_res), DATA_W'(got.full_res));
      compare("empty_res", DATA_W'(want.empty_res), DATA_W'(got.empty_res));
    endfunction

    function int unsigned waiting();
      return pending_status.size();
    endfunction

    function logic [DATA_W-1:0] pick_held();
      if (held.size() == 0) return $urandom();
      return held[$urandom_range(0, held.size() - 1)];
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  deque_tracker tracker = new();
  bit           quiet      = 1'b0;
  int unsigned  gap_chance = 20;
  int unsigned  hold_cnt   = 0;
  int unsigned  idle_cycles = 0;

  ring_deque_with_delete #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold_cnt  <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 30);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= $urandom_range(0, 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_word(in_word);
      if (out_valid && !out_stall) tracker.check_word(out_word);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    if (!quiet && gap_chance != 0 && $urandom_range(0, 99) < gap_chance) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{operation: op, data_in: data};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.waiting() != 0);
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       span;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    int unsigned       roll;
    bit                paused;
    mix_t              mix;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;

    sent   = 0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_POP_NEW, 32'h0);
    send_word(OP_POP_OLD, 32'h0);
    send_word(OP_DELETE, 32'h0);
    send_word(OP_CLEAR, 32'h0);
    send_word(OP_W'(OP_SPARE_FIRST), 32'hFFFF_FFFF);
    send_word(OP_W'(OP_SPARE_FIRST + 1), 32'h5555_5555);
    send_word(OP_W'(OP_SPARE_LAST), 32'hAAAA_AAAA);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_PUSH, 32'h0);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_PUSH, 32'h8000_0001);
    send_word(OP_DELETE, 32'h1234_5678);
    send_word(OP_DELETE, 32'hFFFF_FFFF);
    send_word(OP_POP_OLD, 32'h0);
    send_word(OP_POP_NEW, 32'h0);
    send_word(OP_POP_NEW, 32'h0);
    send_word(OP_PUSH, 32'h1);
    send_word(OP_PUSH, 32'h2);
    send_word(OP_W'(OP_SPARE_LAST), 32'h0);
    send_word(OP_CLEAR, 32'h0);
    send_word(OP_PUSH, 32'h3);
    send_word(OP_POP_OLD, 32'h0);
    send_word(OP_PUSH, 32'h7FFF_FFFE);
    send_word(OP_DELETE, 32'h7FFF_FFFE);

    while (sent < RANDOM_WORDS) begin
      mix        = mix_t'($urandom_range(0, 2));
      span       = $urandom_range(10, 60);
      gap_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      case (mix)
        MIX_FILL:  begin push_pct = 72; pop_pct = 10; end
        MIX_DRAIN: begin push_pct = 22; pop_pct = 60; end
        default:   begin push_pct = 42; pop_pct = 40; end
      endcase
      repeat (span) begin
        roll = $urandom_range(0, 99);
        val  = pool_value();
        if (roll < push_pct) begin
          op = OP_PUSH;
        end else if (roll < push_pct + pop_pct) begin
          op = $urandom_range(0, 1) ? OP_POP_NEW : OP_POP_OLD;
        end else if (roll < 95) begin
          op = OP_DELETE;
          if ($urandom_range(0, 9) < 7) val = tracker.pick_held();
        end else if (roll < 97) begin
          op = OP_CLEAR;
        end else begin
          op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        send_word(op, val);
        if (op < OP_SPARE_FIRST) sent++;
        if (!paused && sent >= RANDOM_WORDS / 2) begin
          paused = 1'b1;
          drain_all();
        end
        if (sent >= RANDOM_WORDS - QUIET_TAIL) quiet <= 1'b1;
      end
    end

    drain_all();
    repeat (DEPTH + 10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rdqd_pkg.sv
hdl/rdqd_ram.sv
hdl/rdqd_ctrl.sv
hdl/rdqd_dpath.sv
hdl/ring_deque_with_delete.sv
sim/testbench.sv
